// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, muted while reset is asserted
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/iesp_pkg.sv -----
`default_nettype none

package iesp_pkg;

  localparam int unsigned HASH_BYTES  = 20;
  localparam int unsigned HASH_IDX_W  = $clog2(HASH_BYTES);
  localparam int unsigned FIXED_BYTES = 40;
  localparam int unsigned FIXED_WORDS = FIXED_BYTES / 4;
  localparam int unsigned FLAGS_OFF   = FIXED_BYTES + HASH_BYTES;
  localparam int unsigned PATH_OFF    = FLAGS_OFF + 2;
  localparam int unsigned OFF_W       = 13;
  localparam int unsigned PLEN_W      = 12;
  localparam int unsigned ALIGN_MASK  = 7;
  localparam logic [31:0] INDEX_MAGIC = 32'h4449_5243;

  typedef enum logic [1:0] {
    KIND_HDR_OK  = 2'd0,
    KIND_HDR_BAD = 2'd1,
    KIND_PATH    = 2'd2,
    KIND_ENTRY   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } iesp_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [63:0]        change_time;
    logic [63:0]        modify_time;
    logic [63:0]        device_and_inode;
    logic [31:0]        mode_or_version;
    logic [63:0]        user_and_group;
    logic [31:0]        size_or_count;
    logic [63:0]        hash_upper;
    logic [63:0]        hash_middle;
    logic [31:0]        hash_lower;
    logic [PLEN_W-1:0]  path_info;
    logic               last_entry;
  } iesp_result_t;

endpackage

`default_nettype wire

// ----- sv/iesp_in_stage.sv -----
`default_nettype none

module iesp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_byte,
  input  logic                adv,
  output logic                item_valid,
  output iesp_pkg::iesp_item_t item
);
  import iesp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  iesp_item_t item_r;
  logic       take;

  assign in_stall   = valid_r && !adv;
  assign take       = in_valid && !in_stall;
  assign item_valid = valid_r && adv;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r.data_byte  <= in_data_byte;
      item_r.first_byte <= in_first_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/iesp_parse.sv -----
`default_nettype none

module iesp_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  input  iesp_pkg::iesp_item_t   item,
  output logic                   res_valid,
  output iesp_pkg::iesp_result_t res
);
  import iesp_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_HEADER,
    PH_ENTRY
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [OFF_W-1:0]   byte_offset_r, byte_offset_nxt;
  logic [31:0]        word_shift_r, word_shift_nxt;
  logic [PLEN_W-1:0]  path_length_r, path_length_nxt;
  logic [31:0]        entries_left_r, entries_left_nxt;
  logic [31:0]        field_store_r;
  logic [31:0]        entry_words_r [FIXED_WORDS];
  logic [7:0]         hash_store_r [HASH_BYTES];

  logic                  field_we;
  logic                  word_we;
  logic [3:0]            word_idx;
  logic                  hash_we;
  logic [HASH_IDX_W-1:0] hash_idx;

  always_comb begin
    phase_t           ph;
    logic [OFF_W-1:0] off;
    logic [31:0]      ws;
    logic [31:0]      ws_shl;
    logic [OFF_W-1:0] hash_off;
    logic [OFF_W-1:0] path_end;
    logic [OFF_W:0]   entry_end;
    logic [OFF_W:0]   off_inc;

    phase_nxt        = phase_r;
    byte_offset_nxt  = byte_offset_r;
    word_shift_nxt   = word_shift_r;
    path_length_nxt  = path_length_r;
    entries_left_nxt = entries_left_r;
    field_we         = 1'b0;
    word_we          = 1'b0;
    hash_we          = 1'b0;
    res_valid        = 1'b0;
    res              = '0;

    ph        = item.first_byte ? PH_HEADER : phase_r;
    off       = item.first_byte ? '0 : byte_offset_r;
    ws        = item.first_byte ? '0 : word_shift_r;
    ws_shl    = {ws[23:0], item.data_byte};
    hash_off  = off - OFF_W'(FIXED_BYTES);
    hash_idx  = hash_off[HASH_IDX_W-1:0];
    word_idx  = off[5:2];
    path_end  = OFF_W'(PATH_OFF) + {{(OFF_W-PLEN_W){1'b0}}, path_length_r};
    entry_end = ((OFF_W+1)'(PATH_OFF + 1 + ALIGN_MASK)
                 + {{(OFF_W+1-PLEN_W){1'b0}}, path_length_r})
                & ~(OFF_W+1)'(ALIGN_MASK);
    off_inc   = {1'b0, off} + (OFF_W+1)'(1);

    if (item_valid && (item.first_byte || phase_r != PH_WAIT)) begin
      phase_nxt       = ph;
      byte_offset_nxt = off + OFF_W'(1);
      word_shift_nxt  = ws;
      unique case (ph)
        PH_HEADER: begin
          word_shift_nxt = ws_shl;
          if (off == OFF_W'(3) && ws_shl != INDEX_MAGIC) begin
            phase_nxt       = PH_WAIT;
            byte_offset_nxt = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_HDR_BAD;
          end else if (off == OFF_W'(7)) begin
            field_we = 1'b1;
          end else if (off == OFF_W'(11)) begin
            entries_left_nxt    = ws_shl;
            byte_offset_nxt     = '0;
            phase_nxt           = (ws_shl != '0) ? PH_ENTRY : PH_WAIT;
            res_valid           = 1'b1;
            res.kind            = KIND_HDR_OK;
            res.mode_or_version = field_store_r;
            res.size_or_count   = ws_shl;
          end
        end
        PH_ENTRY: begin
          if (off < OFF_W'(FIXED_BYTES)) begin
            word_shift_nxt = ws_shl;
            word_we        = (off[1:0] == 2'd3);
          end else if (off < OFF_W'(FLAGS_OFF)) begin
            hash_we = 1'b1;
          end else if (off == OFF_W'(FLAGS_OFF)) begin
            word_shift_nxt = {24'd0, item.data_byte};
          end else if (off == OFF_W'(FLAGS_OFF + 1)) begin
            path_length_nxt = {ws[3:0], item.data_byte};
          end else if (off < path_end) begin
            res_valid     = 1'b1;
            res.kind      = KIND_PATH;
            res.path_info = {{(PLEN_W-8){1'b0}}, item.data_byte};
          end else if (off_inc >= entry_end) begin
            entries_left_nxt     = entries_left_r - 32'd1;
            byte_offset_nxt      = '0;
            res_valid            = 1'b1;
            res.kind             = KIND_ENTRY;
            res.change_time      = {entry_words_r[0], entry_words_r[1]};
            res.modify_time      = {entry_words_r[2], entry_words_r[3]};
            res.device_and_inode = {entry_words_r[4], entry_words_r[5]};
            res.mode_or_version  = entry_words_r[6];
            res.user_and_group   = {entry_words_r[7], entry_words_r[8]};
            res.size_or_count    = entry_words_r[9];
            for (int i = 0; i < 8; i++) begin
              res.hash_upper[63-8*i -: 8]  = hash_store_r[i];
              res.hash_middle[63-8*i -: 8] = hash_store_r[8+i];
            end
            for (int i = 0; i < 4; i++) begin
              res.hash_lower[31-8*i -: 8] = hash_store_r[16+i];
            end
            res.path_info  = path_length_r;
            res.last_entry = (entries_left_r == 32'd1);
            if (entries_left_r == 32'd1) begin
              phase_nxt = PH_WAIT;
            end
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT;
      byte_offset_r  <= '0;
      word_shift_r   <= '0;
      path_length_r  <= '0;
      entries_left_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_offset_r  <= byte_offset_nxt;
      word_shift_r   <= word_shift_nxt;
      path_length_r  <= path_length_nxt;
      entries_left_r <= entries_left_nxt;
    end
    if (field_we) begin
      field_store_r <= word_shift_nxt;
    end
    if (word_we) begin
      entry_words_r[word_idx] <= word_shift_nxt;
    end
    if (hash_we) begin
      hash_store_r[hash_idx] <= item.data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/iesp_out_reg.sv -----
`default_nettype none

module iesp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  iesp_pkg::iesp_result_t res,
  output logic                   adv,
  output logic                   out_valid,
  input  logic                   out_stall,
  output iesp_pkg::iesp_result_t out_res
);
  import iesp_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  iesp_result_t res_r;

  assign adv       = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- sv/index_entry_stream_parser.sv -----
// Index image parser: takes one image byte per cycle while out_stall is low (in_first_byte
// marks the start of an image) and gives header, path-byte and entry results. Throughput
// is one byte per cycle while out_stall is low; a result is taken into the output register
// after its byte passes through the input register and then the single-pass parse logic.
// Bytes that give no result still pass through both. While the output register holds a
// stalled result and the input register is full, in_stall stays high.
`default_nettype none
`include "assert_macros.svh"

module index_entry_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [63:0] out_change_time,
  output logic [63:0] out_modify_time,
  output logic [63:0] out_device_and_inode,
  output logic [31:0] out_mode_or_version,
  output logic [63:0] out_user_and_group,
  output logic [31:0] out_size_or_count,
  output logic [63:0] out_hash_upper,
  output logic [63:0] out_hash_middle,
  output logic [31:0] out_hash_lower,
  output logic [11:0] out_path_info,
  output logic        out_last_entry
);
  import iesp_pkg::*;

  logic         adv;
  logic         item_valid;
  iesp_item_t   item;
  logic         res_valid;
  iesp_result_t res;
  iesp_result_t out_res;

  iesp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .adv          (adv),
    .item_valid   (item_valid),
    .item         (item)
  );

  iesp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  iesp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .adv      (adv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_kind             = out_res.kind;
  assign out_change_time      = out_res.change_time;
  assign out_modify_time      = out_res.modify_time;
  assign out_device_and_inode = out_res.device_and_inode;
  assign out_mode_or_version  = out_res.mode_or_version;
  assign out_user_and_group   = out_res.user_and_group;
  assign out_size_or_count    = out_res.size_or_count;
  assign out_hash_upper       = out_res.hash_upper;
  assign out_hash_middle      = out_res.hash_middle;
  assign out_hash_lower       = out_res.hash_lower;
  assign out_path_info        = out_res.path_info;
  assign out_last_entry       = out_res.last_entry;

  `ASSERT_IMPL(a_stall_from_output, in_stall, out_valid && out_stall,
    "input stalled without output back pressure")
  `ASSERT_IMPL(a_result_has_room, res_valid, adv,
    "parse result produced while output register is blocked")
  `ASSERT_CLK(a_reject_is_bare,
    !(out_valid && out_kind == KIND_HDR_BAD) ||
    (out_size_or_count == '0 && out_path_info == '0 && !out_last_entry),
    "header rejection carries payload")

endmodule

`default_nettype wire
